FILE: design/label_propagation_vertex_update_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the label propagation vertex update unit
// Shared concurrent-check forms clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LABEL_PROPAGATION_VERTEX_UPDATE_UNIT_DEFINES_SVH
`define LABEL_PROPAGATION_VERTEX_UPDATE_UNIT_DEFINES_SVH

// same-cycle implication
`define LPV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpv check failed");

// next-cycle implication
`define LPV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpv check failed");

`endif

FILE: design/lpv_pkg.sv
// ----------------------------------------------------------------------------
// lpv_pkg
// Types, sizes and codes of the label propagation vertex update unit.
// ----------------------------------------------------------------------------
`default_nettype none
package lpv_pkg;

  localparam int NUM_VERTICES = 1024;
  localparam int NUM_LABELS   = 8;
  localparam int VERT_W  = 10;
  localparam int LABEL_W = 3;
  localparam int ADDR_W  = VERT_W + LABEL_W;
  localparam int PROB_W  = 16;
  localparam int ACC_W   = 48;
  localparam int SUM_W   = ACC_W + LABEL_W;   // sum of all accumulators
  localparam int MIX_W   = 33;                // alpha*old + (1-alpha)*n
  localparam int TOT_W   = MIX_W + LABEL_W;   // sum of all mixes
  localparam int DIV_W   = SUM_W;
  localparam int QUOT_W  = PROB_W + 1;

  localparam logic [15:0] ALPHA_RESET = 16'd9830;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_EDGE  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  vertex;
    logic [9:0]  neighbour;
    logic [2:0]  label;
    logic [15:0] value;
    logic        seed;
    logic [15:0] weight;
    logic        last;
  } in_req_t;

  typedef struct packed {
    logic [9:0]  out_vertex;
    logic [2:0]  out_label;
    logic [15:0] probability;
    logic        end_of_vector;
    logic        error;
  } out_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: design/label_propagation_vertex_update_unit.sv
// ----------------------------------------------------------------------------
// label_propagation_vertex_update_unit
// Per-vertex label vectors in RAM, edge accumulation and in-place update.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_stall is high while it is in work.
// Write and ignored requests finish in idle; a read passes the read, load
// and output states and waits on output stalls. Each edge steps through the
// labels one at a time, as the probability RAM has a single read port, with
// a read, a multiply and a saturating add per label. A last edge of a
// non-seed vertex then runs two normalize passes through the shared 17-step
// divider and emits each result through the same states as a read. After
// reset the seed flags of all 1024 vertices are cleared with in_stall high.
`default_nettype none
`include "label_propagation_vertex_update_unit_defines.svh"
module label_propagation_vertex_update_unit (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire lpv_pkg::in_req_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output lpv_pkg::out_rsp_t     out_data,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata
);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_ARD   = 5'd2;
  localparam logic [4:0] S_AMUL  = 5'd3;
  localparam logic [4:0] S_AADD  = 5'd4;
  localparam logic [4:0] S_SEED  = 5'd5;
  localparam logic [4:0] S_SUM   = 5'd6;
  localparam logic [4:0] S_CHK   = 5'd7;
  localparam logic [4:0] S_NDIV  = 5'd8;
  localparam logic [4:0] S_NWAIT = 5'd9;
  localparam logic [4:0] S_MIX1  = 5'd10;
  localparam logic [4:0] S_MIX2  = 5'd11;
  localparam logic [4:0] S_TCHK  = 5'd12;
  localparam logic [4:0] S_TDIV  = 5'd13;
  localparam logic [4:0] S_TWAIT = 5'd14;
  localparam logic [4:0] S_ERD   = 5'd15;
  localparam logic [4:0] S_ELD   = 5'd16;
  localparam logic [4:0] S_EOUT  = 5'd17;

  localparam int AW = lpv_pkg::ADDR_W;
  localparam int LW = lpv_pkg::LABEL_W;
  localparam int VW = lpv_pkg::VERT_W;
  localparam int DIV_W = lpv_pkg::DIV_W;
  localparam int MIX_W = lpv_pkg::MIX_W;
  localparam logic [LW-1:0] IDX_LAST = LW'(lpv_pkg::NUM_LABELS - 1);
  localparam logic [VW-1:0] CLR_LAST = VW'(lpv_pkg::NUM_VERTICES - 1);

  logic [4:0]    state_r, state_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] clr_r;
  logic [15:0]   alpha_r;
  logic          out_valid_r;
  logic          single_r, err_r, err_nxt;
  logic          acc_clr;

  // latched request
  logic [VW-1:0] vert_r, nb_r;
  logic [LW-1:0] lab_r;
  logic [15:0]   weight_r;
  logic          last_r;

  logic [31:0]                prod_r;
  logic [lpv_pkg::ACC_W-1:0]  acc_r [lpv_pkg::NUM_LABELS];
  logic [lpv_pkg::ACC_W:0]    acc_sum;
  logic [lpv_pkg::ACC_W-1:0]  acc_new;
  logic [lpv_pkg::SUM_W-1:0]  sum_r;
  logic [lpv_pkg::PROB_W-1:0] n_r;
  logic [31:0]                mixa_r;
  logic [lpv_pkg::MIX_W-1:0]  mix_r [lpv_pkg::NUM_LABELS];
  logic [lpv_pkg::MIX_W-1:0]  mix_new;
  logic [16:0]                beta;
  logic [lpv_pkg::TOT_W-1:0]  tot_r;
  logic [lpv_pkg::PROB_W-1:0] quot_sat;

  logic          in_acc;
  logic          p_we, p_re, s_we, s_re;
  logic [AW-1:0] p_waddr, p_raddr;
  logic [15:0]   p_wdata, p_rdata;
  logic [VW-1:0] s_waddr;
  logic          s_wdata, s_rdata;

  lpv_pkg::div_req_t div_req;
  lpv_pkg::div_rsp_t div_rsp;
  lpv_pkg::out_rsp_t out_r;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // probability and seed memories
  lpv_ram #(.WIDTH(lpv_pkg::PROB_W), .DEPTH(lpv_pkg::NUM_VERTICES * lpv_pkg::NUM_LABELS))
    u_prob (.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
            .re(p_re), .raddr(p_raddr), .rdata(p_rdata));

  lpv_ram #(.WIDTH(1), .DEPTH(lpv_pkg::NUM_VERTICES))
    u_seed (.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
            .re(s_re), .raddr(vert_r), .rdata(s_rdata));

  lpv_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // arithmetic helpers
  assign acc_sum  = {1'b0, acc_r[idx_r]} + {17'd0, prod_r};
  assign acc_new  = acc_sum[lpv_pkg::ACC_W] ? '1 : acc_sum[lpv_pkg::ACC_W-1:0];
  assign beta     = 17'h10000 - {1'b0, alpha_r};
  assign mix_new  = {1'b0, mixa_r} + MIX_W'(beta * n_r);
  assign quot_sat = div_rsp.quot[lpv_pkg::QUOT_W-1] ? '1 : div_rsp.quot[15:0];

  // memory ports and divider request
  always_comb begin
    p_we    = 1'b0;
    p_waddr = {in_data.vertex, in_data.label};
    p_wdata = in_data.value;
    p_re    = 1'b0;
    p_raddr = {vert_r, idx_r};
    s_we    = 1'b0;
    s_waddr = in_data.vertex;
    s_wdata = in_data.seed;
    s_re    = (state_r == S_SEED);
    div_req.start = 1'b0;
    div_req.num   = {3'd0, acc_r[idx_r]};
    div_req.den   = sum_r;
    unique case (state_r)
      S_CLR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        s_wdata = 1'b0;
      end
      S_IDLE: begin
        p_we = in_acc && (in_data.mode == lpv_pkg::MODE_WRITE);
        s_we = p_we;
      end
      S_ARD: begin
        p_re    = 1'b1;
        p_raddr = {nb_r, idx_r};
      end
      S_NDIV: div_req.start = 1'b1;
      S_NWAIT: p_re = div_rsp.done;
      S_TDIV: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(mix_r[idx_r]);
        div_req.den   = DIV_W'(tot_r);
      end
      S_TWAIT: begin
        p_we    = div_rsp.done;
        p_waddr = {vert_r, idx_r};
        p_wdata = quot_sat;
      end
      S_ERD: begin
        p_re    = 1'b1;
        p_raddr = single_r ? {vert_r, lab_r} : {vert_r, idx_r};
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    acc_clr   = 1'b0;
    unique case (state_r)
      S_CLR:  if (clr_r == CLR_LAST) state_nxt = S_IDLE;
      S_IDLE: begin
        idx_nxt = '0;
        err_nxt = 1'b0;
        if (in_acc && in_data.mode == lpv_pkg::MODE_EDGE) state_nxt = S_ARD;
        if (in_acc && in_data.mode == lpv_pkg::MODE_READ) state_nxt = S_ERD;
      end
      S_ARD:  state_nxt = S_AMUL;
      S_AMUL: state_nxt = S_AADD;
      S_AADD: begin
        idx_nxt = idx_r + LW'(1);
        if (idx_r != IDX_LAST) state_nxt = S_ARD;
        else if (last_r)       state_nxt = S_SEED;
        else                   state_nxt = S_IDLE;
      end
      S_SEED: state_nxt = S_SUM;
      S_SUM: begin
        idx_nxt = idx_r + LW'(1);
        if (idx_r == IDX_LAST) state_nxt = S_CHK;
      end
      S_CHK: begin
        priority if (s_rdata) begin
          state_nxt = S_ERD;
        end else if (sum_r == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_NDIV;
        end
      end
      S_NDIV:  state_nxt = S_NWAIT;
      S_NWAIT: if (div_rsp.done) state_nxt = S_MIX1;
      S_MIX1:  state_nxt = S_MIX2;
      S_MIX2: begin
        idx_nxt   = idx_r + LW'(1);
        state_nxt = (idx_r == IDX_LAST) ? S_TCHK : S_NDIV;
      end
      S_TCHK: begin
        if (tot_r == '0) begin
          err_nxt   = 1'b1;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_TDIV;
        end
      end
      S_TDIV:  state_nxt = S_TWAIT;
      S_TWAIT: begin
        if (div_rsp.done) begin
          idx_nxt   = idx_r + LW'(1);
          state_nxt = (idx_r == IDX_LAST) ? S_ERD : S_TDIV;
        end
      end
      S_ERD: state_nxt = S_ELD;
      S_ELD: state_nxt = S_EOUT;
      S_EOUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + LW'(1);
          if (single_r || idx_r == IDX_LAST) begin
            state_nxt = S_IDLE;
            acc_clr   = !single_r;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      clr_r       <= '0;
      alpha_r     <= lpv_pkg::ALPHA_RESET;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
      for (int i = 0; i < lpv_pkg::NUM_LABELS; i++) acc_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
      clr_r   <= clr_r + VW'(1);
      if (cfg_we) alpha_r <= cfg_wdata;
      if (state_r == S_ELD) out_valid_r <= 1'b1;
      else if (state_r == S_EOUT && !out_stall) out_valid_r <= 1'b0;
      if (state_r == S_AADD) acc_r[idx_r] <= acc_new;
      if (acc_clr) begin
        for (int i = 0; i < lpv_pkg::NUM_LABELS; i++) acc_r[i] <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_acc) begin
      vert_r   <= in_data.vertex;
      nb_r     <= in_data.neighbour;
      lab_r    <= in_data.label;
      weight_r <= in_data.weight;
      last_r   <= in_data.last;
      single_r <= (in_data.mode == lpv_pkg::MODE_READ);
    end
    if (state_r == S_AMUL) prod_r <= weight_r * p_rdata;
    if (state_r == S_SEED) sum_r <= '0;
    if (state_r == S_SUM)  sum_r <= sum_r + lpv_pkg::SUM_W'(acc_r[idx_r]);
    if (state_r == S_CHK)  tot_r <= '0;
    if (state_r == S_NWAIT && div_rsp.done) n_r <= quot_sat;
    if (state_r == S_MIX1) mixa_r <= alpha_r * p_rdata;
    if (state_r == S_MIX2) begin
      mix_r[idx_r] <= mix_new;
      tot_r        <= tot_r + lpv_pkg::TOT_W'(mix_new);
    end
    if (state_r == S_ELD) begin
      out_r.out_vertex    <= vert_r;
      out_r.out_label     <= single_r ? lab_r : idx_r;
      out_r.probability   <= p_rdata;
      out_r.end_of_vector <= single_r || (idx_r == IDX_LAST);
      out_r.error         <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `LPV_ASSERT_NOW(a_out_only_in_eout, out_valid_r, state_r == S_EOUT)
  `LPV_ASSERT_NOW(a_div_done_waiting, div_rsp.done,
                  state_r == S_NWAIT || state_r == S_TWAIT)
  `LPV_ASSERT_NEXT(a_edge_goes_accumulate,
                   in_acc && in_data.mode == lpv_pkg::MODE_EDGE, state_r == S_ARD)
  `LPV_ASSERT_NOW(a_no_write_on_error, p_we && state_r == S_TWAIT, !err_r)

endmodule
`default_nettype wire

FILE: design/lpv_ram.sv
// ----------------------------------------------------------------------------
// lpv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module lpv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: design/lpv_div.sv
// ----------------------------------------------------------------------------
// lpv_div
// Restoring divider for num <= den, giving the quotient of num*2^16/den.
// ----------------------------------------------------------------------------
`default_nettype none
module lpv_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lpv_pkg::div_req_t req,
  output lpv_pkg::div_rsp_t      rsp
);

  localparam int RW = lpv_pkg::DIV_W + 1;
  localparam logic [4:0] LAST_STEP = 5'(lpv_pkg::QUOT_W - 1);

  logic              run_r, done_r;
  logic [4:0]        cnt_r;
  logic [RW-1:0]     rem_r, rem_sh, rem_nxt;
  logic [RW-1:0]     den_r;
  logic [lpv_pkg::QUOT_W-1:0] quot_r;
  logic              ge;

  // first step compares without shifting, the rest shift one bit in
  always_comb begin
    rem_sh  = (cnt_r == 5'd0) ? rem_r : {rem_r[RW-2:0], 1'b0};
    ge      = (rem_sh >= den_r);
    rem_nxt = ge ? (rem_sh - den_r) : rem_sh;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= 5'd0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == LAST_STEP) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= {1'b0, req.num};
      den_r  <= {1'b0, req.den};
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[lpv_pkg::QUOT_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
`default_nettype wire
